@@ rtl/svp_pkg.sv @@
// svp_pkg: shared types, codes and lookup functions for the space vector pwm block
// no dependencies; used by svp_div and space_vector_pwm
package svp_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ALPHA_SCALE = 2'd0,
		REG_BETA_SCALE  = 2'd1,
		REG_MAX_ACTIVE  = 2'd2,
		REG_QUARTER     = 2'd3
	} reg_idx_t;

	// reset values of the configuration registers
	localparam logic [15:0] ALPHA_SCALE_RST = 16'd56756;
	localparam logic [15:0] BETA_SCALE_RST  = 16'd32768;
	localparam logic [14:0] MAX_ACTIVE_RST  = 15'd2000;
	localparam logic [14:0] QUARTER_RST     = 15'd1125;

	// divider shape: quotient bits and bits resolved per stage
	localparam int QUO_BITS   = 15;
	localparam int STEP_BITS  = 3;
	localparam int DIV_STAGES = QUO_BITS / STEP_BITS;

	// motor codes
	localparam logic [1:0] MOTOR_YAW   = 2'd0;
	localparam logic [1:0] MOTOR_ROLL  = 2'd1;
	localparam logic [1:0] MOTOR_PITCH = 2'd2;

	// which of x, y, z a time uses
	typedef enum logic [1:0] {
		VAR_X = 2'd0,
		VAR_Y = 2'd1,
		VAR_Z = 2'd2
	} var_t;

	// phase letters
	typedef enum logic [1:0] {
		PH_A = 2'd0,
		PH_B = 2'd1,
		PH_C = 2'd2
	} phase_t;

	typedef struct packed {
		var_t   v1;
		logic   n1;
		var_t   v2;
		logic   n2;
		phase_t p0;
		phase_t p1;
		phase_t p2;
	} sect_t;

	// per-sector choice of active times and phase order
	function automatic sect_t sect_lookup(input logic [2:0] code);
		sect_t d;
		d = '{VAR_X, 1'b0, VAR_X, 1'b0, PH_A, PH_A, PH_A};
		unique case (code)
			3'd1: d = '{VAR_Z, 1'b0, VAR_Y, 1'b0, PH_B, PH_A, PH_C};
			3'd2: d = '{VAR_Y, 1'b0, VAR_X, 1'b1, PH_A, PH_C, PH_B};
			3'd3: d = '{VAR_Z, 1'b1, VAR_X, 1'b0, PH_A, PH_B, PH_C};
			3'd4: d = '{VAR_X, 1'b1, VAR_Z, 1'b0, PH_C, PH_B, PH_A};
			3'd5: d = '{VAR_X, 1'b0, VAR_Y, 1'b1, PH_B, PH_C, PH_A};
			3'd6: d = '{VAR_Y, 1'b1, VAR_Z, 1'b1, PH_C, PH_A, PH_B};
			default: d = '{VAR_X, 1'b0, VAR_X, 1'b0, PH_A, PH_A, PH_A};
		endcase
		return d;
	endfunction

	function automatic logic sect_ok(input logic [2:0] code);
		return (code != 3'd0) && (code != 3'd7);
	endfunction

endpackage

@@ rtl/space_vector_pwm.sv @@
// space_vector_pwm: top level, alpha/beta voltage to three timer compare values
// depends on svp_pkg and svp_div
//
// One transaction may start in every clock cycle and busy is always low; each result
// appears with done in order, and the receiver cannot stall it. Each transaction passes
// through the two scaling multipliers, the five-stage divider that rescales the active
// times when their sum passes max_active_time, and the output stages. Configuration
// writes are always taken (cfg_ready high) and must only be made while no transaction
// is in flight.
module space_vector_pwm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] volt_alpha,
	input  logic signed [15:0] volt_beta,
	input  logic        [1:0]  motor_id,
	output logic               done,
	output logic        [15:0] chan0_compare,
	output logic        [15:0] chan1_compare,
	output logic        [15:0] chan2_compare,
	output logic        [2:0]  sector_code,
	output logic               rescaled,
	output logic        [1:0]  motor_echo,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);
	import svp_pkg::*;

	typedef struct packed {
		logic signed [15:0] v1;
		logic signed [15:0] v2;
		logic               resc;
		logic [2:0]         sector;
		logic [1:0]         motor;
	} side_t;

	logic [15:0] alpha_scale_q;
	logic [15:0] beta_scale_q;
	logic [14:0] max_active_q;
	logic [14:0] quarter_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_scale_q <= ALPHA_SCALE_RST;
			beta_scale_q  <= BETA_SCALE_RST;
			max_active_q  <= MAX_ACTIVE_RST;
			quarter_q     <= QUARTER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ALPHA_SCALE: alpha_scale_q <= cfg_data;
				REG_BETA_SCALE:  beta_scale_q  <= cfg_data;
				REG_MAX_ACTIVE:  max_active_q  <= cfg_data[14:0];
				REG_QUARTER:     quarter_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// stage 1: q16 scaling products
	logic               valid_s1;
	logic signed [32:0] prod_a_s1;
	logic signed [32:0] prod_b_s1;
	logic [1:0]         motor_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		prod_a_s1 <= volt_alpha * $signed({1'b0, alpha_scale_q});
		prod_b_s1 <= volt_beta * $signed({1'b0, beta_scale_q});
		motor_s1  <= motor_id;
	end

	// stage 2: x, y, z, sector and the active time sum
	logic signed [15:0] a_c, b_c, y_c, z_c, v1_c, v2_c;
	logic signed [16:0] apb_c, amb_c, bma_c, t1_c, t2_c;
	logic signed [15:0] t_c;
	logic [2:0]         sector_c;
	sect_t              desc_c;

	function automatic logic signed [15:0] pick(input var_t v, input logic signed [15:0] x,
		input logic signed [15:0] y, input logic signed [15:0] z);
		logic signed [15:0] r;
		r = x;
		unique case (v)
			VAR_X: r = x;
			VAR_Y: r = y;
			VAR_Z: r = z;
			default: r = x;
		endcase
		return r;
	endfunction

	always_comb begin
		a_c = prod_a_s1[31:16];
		b_c = prod_b_s1[31:16];
		apb_c = 17'(a_c) + 17'(b_c);
		amb_c = 17'(a_c) - 17'(b_c);
		bma_c = 17'(b_c) - 17'(a_c);
		y_c = apb_c[16:1];
		z_c = bma_c[16:1];
		sector_c = {apb_c[16], !amb_c[16], !b_c[15]};
		desc_c = sect_lookup(sector_c);
		v1_c = pick(desc_c.v1, b_c, y_c, z_c);
		v2_c = pick(desc_c.v2, b_c, y_c, z_c);
		t1_c = desc_c.n1 ? -17'(v1_c) : 17'(v1_c);
		t2_c = desc_c.n2 ? -17'(v2_c) : 17'(v2_c);
		t_c = 16'(t1_c + t2_c);
	end

	logic               valid_s2;
	side_t              side_s2;
	logic signed [15:0] t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2.v1     <= v1_c;
		side_s2.v2     <= v2_c;
		side_s2.resc   <= sect_ok(sector_c) && (t_c > $signed({1'b0, max_active_q}));
		side_s2.sector <= sector_c;
		side_s2.motor  <= motor_s1;
		t_s2           <= t_c;
	end

	// stage 3: numerators of the rescale
	logic               valid_s3;
	side_t              side_s3;
	logic signed [31:0] num1_s3, num2_s3;
	logic [15:0]        t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		num1_s3 <= side_s2.v1 * $signed({1'b0, max_active_q});
		num2_s3 <= side_s2.v2 * $signed({1'b0, max_active_q});
		side_s3 <= side_s2;
		t_s3    <= t_s2;
	end

	// rescale dividers with the sideband delayed to match
	logic               dv1, dv2;
	logic signed [15:0] quo1, quo2;
	side_t              side_d [DIV_STAGES];

	svp_div u_div1 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s3), .num(num1_s3[30:0]),
		.den(t_s3), .out_valid(dv1), .quo(quo1)
	);

	svp_div u_div2 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s3), .num(num2_s3[30:0]),
		.den(t_s3), .out_valid(dv2), .quo(quo2)
	);

	always_ff @(posedge clk) begin
		side_d[0] <= side_s3;
		for (int i = 1; i < DIV_STAGES; i++) begin
			side_d[i] <= side_d[i-1];
		end
	end

	// stage 4: final times and first phase
	side_t              sd_c;
	sect_t              desc4_c;
	logic signed [15:0] f1_c, f2_c;
	logic signed [16:0] u1_c, u2_c;
	logic signed [18:0] first_c;

	always_comb begin
		sd_c = side_d[DIV_STAGES-1];
		desc4_c = sect_lookup(sd_c.sector);
		f1_c = sd_c.resc ? quo1 : sd_c.v1;
		f2_c = sd_c.resc ? quo2 : sd_c.v2;
		u1_c = desc4_c.n1 ? -17'(f1_c) : 17'(f1_c);
		u2_c = desc4_c.n2 ? -17'(f2_c) : 17'(f2_c);
		first_c = ($signed({3'b0, quarter_q, 1'b0}) - (19'(u1_c) + 19'(u2_c))) >>> 1;
	end

	logic        valid_s4;
	side_t       side_s4;
	logic [15:0] q0_s4, t1_s4, t2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= dv1 && dv2;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= sd_c;
		q0_s4   <= first_c[15:0];
		t1_s4   <= u1_c[15:0];
		t2_s4   <= u2_c[15:0];
	end

	// stage 5: remaining phases, phase order and channel routing
	sect_t       desc5_c;
	logic [15:0] q1_c, q2_c;
	logic [15:0] ph_c [3];
	logic [15:0] c0_c, c1_c, c2_c;

	always_comb begin
		desc5_c = sect_lookup(side_s4.sector);
		q1_c = q0_s4 + t1_s4;
		q2_c = q1_c + t2_s4;
		for (int i = 0; i < 3; i++) begin
			ph_c[i] = '0;
		end
		if (sect_ok(side_s4.sector)) begin
			ph_c[desc5_c.p0] = q0_s4;
			ph_c[desc5_c.p1] = q1_c;
			ph_c[desc5_c.p2] = q2_c;
		end
		c0_c = '0;
		c1_c = '0;
		c2_c = '0;
		unique case (side_s4.motor)
			MOTOR_YAW: begin
				c0_c = ph_c[PH_B]; c1_c = ph_c[PH_C]; c2_c = ph_c[PH_A];
			end
			MOTOR_ROLL: begin
				c0_c = ph_c[PH_A]; c1_c = ph_c[PH_C]; c2_c = ph_c[PH_B];
			end
			MOTOR_PITCH: begin
				c0_c = ph_c[PH_C]; c1_c = ph_c[PH_B]; c2_c = ph_c[PH_A];
			end
			default: ;
		endcase
	end

	logic        valid_s5;
	logic [15:0] c0_s5, c1_s5, c2_s5;
	side_t       side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		c0_s5   <= c0_c;
		c1_s5   <= c1_c;
		c2_s5   <= c2_c;
		side_s5 <= side_s4;
	end

	assign done          = valid_s5;
	assign chan0_compare = c0_s5;
	assign chan1_compare = c1_s5;
	assign chan2_compare = c2_s5;
	assign sector_code   = side_s5.sector;
	assign rescaled      = side_s5.resc;
	assign motor_echo    = side_s5.motor;

`ifndef SYNTHESIS
	// fixed latency from start to done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##10 done) else $error("result missing after start");

	// both dividers stay in lockstep
	a_div_lock: assert property (@(posedge clk) disable iff (!arst_n)
		dv1 == dv2) else $error("divider valids disagree");

	// rescale only for a real sector
	a_resc_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rescaled) |-> (sector_code != 3'd0 && sector_code != 3'd7))
		else $error("rescale on invalid sector");

	// unmapped motor gives zero compares
	a_motor3: assert property (@(posedge clk) disable iff (!arst_n)
		(done && motor_echo == 2'd3) |->
		(chan0_compare == 16'd0 && chan1_compare == 16'd0 && chan2_compare == 16'd0))
		else $error("nonzero compare for unmapped motor");
`endif

endmodule

@@ rtl/svp_div.sv @@
// svp_div: pipelined signed-by-positive truncating divider
// depends on svp_pkg
module svp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [30:0] num,
	input  logic        [15:0] den,
	output logic               out_valid,
	output logic signed [15:0] quo
);
	import svp_pkg::*;

	logic [30:0]         mag_c;
	logic [DIV_STAGES-1:0] vld_s;
	logic [30:0]         rem_s [DIV_STAGES];
	logic [QUO_BITS-1:0] quo_s [DIV_STAGES];
	logic [15:0]         den_s [DIV_STAGES];
	logic                neg_s [DIV_STAGES];

	// magnitude of the dividend
	assign mag_c = num[30] ? 31'(-num) : 31'(num);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [30:0]         rin;
		logic [QUO_BITS-1:0] qin;
		logic [15:0]         din;
		logic                nin;
		logic                vin;
		logic [30:0]         r;
		logic [QUO_BITS-1:0] q;

		if (g == 0) begin : g_first
			assign rin = mag_c;
			assign qin = '0;
			assign din = den;
			assign nin = num[30];
			assign vin = in_valid;
		end else begin : g_next
			assign rin = rem_s[g-1];
			assign qin = quo_s[g-1];
			assign din = den_s[g-1];
			assign nin = neg_s[g-1];
			assign vin = vld_s[g-1];
		end

		// restoring steps, most significant quotient bit first
		always_comb begin
			r = rin;
			q = qin;
			for (int j = 0; j < STEP_BITS; j++) begin
				if (r >= ({15'd0, din} << (QUO_BITS - 1 - (g * STEP_BITS + j)))) begin
					r = r - ({15'd0, din} << (QUO_BITS - 1 - (g * STEP_BITS + j)));
					q[QUO_BITS - 1 - (g * STEP_BITS + j)] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= r;
			quo_s[g] <= q;
			den_s[g] <= din;
			neg_s[g] <= nin;
		end
	end

	// apply the dividend sign, truncating toward zero
	assign out_valid = vld_s[DIV_STAGES-1];
	assign quo = neg_s[DIV_STAGES-1] ? 16'(-{1'b0, quo_s[DIV_STAGES-1]})
		: 16'({1'b0, quo_s[DIV_STAGES-1]});

endmodule

@@ bench/space_vector_pwm_checker.sv @@
// space_vector_pwm_checker: watches the command, config and result ports of the pwm block
// predicts compare values, sector and rescale flag per transaction; depends on svp_pkg
module space_vector_pwm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] volt_alpha,
	input  logic signed [15:0] volt_beta,
	input  logic        [1:0]  motor_id,
	input  logic               done,
	input  logic        [15:0] chan0_compare,
	input  logic        [15:0] chan1_compare,
	input  logic        [15:0] chan2_compare,
	input  logic        [2:0]  sector_code,
	input  logic               rescaled,
	input  logic        [1:0]  motor_echo,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 rescale_seen
);
	import svp_pkg::*;

	typedef struct {
		logic [15:0] ch0;
		logic [15:0] ch1;
		logic [15:0] ch2;
		logic [2:0]  sector;
		logic        resc;
		logic [1:0]  motor;
	} compare_set_t;

	compare_set_t compare_q[$];
	logic [15:0]  alpha_k, beta_k;
	logic [14:0]  limit_k, quarter_k;

	// low 16 bits as a signed value
	function automatic longint to_s16(input longint v);
		logic signed [15:0] w;
		w = v[15:0];
		return longint'(w);
	endfunction

	function automatic compare_set_t predict_compare(input logic signed [15:0] va,
			input logic signed [15:0] vb, input logic [1:0] m);
		compare_set_t r;
		longint a, b, t1, t2, tsum, first;
		longint xyz[3];
		logic [15:0] ph[3];
		logic [15:0] q0, q1, q2;
		logic [2:0] sec;
		var_t v1, v2;
		logic n1, n2;
		phase_t p0, p1, p2;
		a = to_s16((longint'(va) * longint'(alpha_k)) >>> 16);
		b = to_s16((longint'(vb) * longint'(beta_k)) >>> 16);
		xyz[0] = b;
		xyz[1] = to_s16((b + a) >>> 1);
		xyz[2] = to_s16((b - a) >>> 1);
		sec = 3'd0;
		if (b >= 0) sec = sec + 3'd1;
		if (a - b >= 0) sec = sec + 3'd2;
		if (a + b < 0) sec = sec + 3'd4;
		ph[0] = '0; ph[1] = '0; ph[2] = '0;
		r.resc = 1'b0;
		// sector table: active times and phase order
		n1 = 1'b0; n2 = 1'b0; v1 = VAR_X; v2 = VAR_X; p0 = PH_A; p1 = PH_A; p2 = PH_A;
		case (sec)
			3'd1: begin v1 = VAR_Z; v2 = VAR_Y; p0 = PH_B; p1 = PH_A; p2 = PH_C; end
			3'd2: begin v1 = VAR_Y; v2 = VAR_X; n2 = 1'b1; p0 = PH_A; p1 = PH_C; p2 = PH_B; end
			3'd3: begin v1 = VAR_Z; n1 = 1'b1; v2 = VAR_X; p0 = PH_A; p1 = PH_B; p2 = PH_C; end
			3'd4: begin v1 = VAR_X; n1 = 1'b1; v2 = VAR_Z; p0 = PH_C; p1 = PH_B; p2 = PH_A; end
			3'd5: begin v1 = VAR_X; v2 = VAR_Y; n2 = 1'b1; p0 = PH_B; p1 = PH_C; p2 = PH_A; end
			3'd6: begin
				v1 = VAR_Y; n1 = 1'b1; v2 = VAR_Z; n2 = 1'b1;
				p0 = PH_C; p1 = PH_A; p2 = PH_B;
			end
			default: ;
		endcase
		if (sec != 3'd0 && sec != 3'd7) begin
			t1 = n1 ? -xyz[v1] : xyz[v1];
			t2 = n2 ? -xyz[v2] : xyz[v2];
			tsum = to_s16(t1 + t2);
			// over the limit: scale both times by limit/sum, truncating
			if (tsum > longint'(limit_k)) begin
				xyz[v1] = to_s16(xyz[v1] * longint'(limit_k) / tsum);
				xyz[v2] = to_s16(xyz[v2] * longint'(limit_k) / tsum);
				t1 = n1 ? -xyz[v1] : xyz[v1];
				t2 = n2 ? -xyz[v2] : xyz[v2];
				r.resc = 1'b1;
			end
			first = (2 * longint'(quarter_k) - (t1 + t2)) >>> 1;
			q0 = first[15:0];
			q1 = 16'(longint'(q0) + t1);
			q2 = 16'(longint'(q1) + t2);
			ph[p0] = q0;
			ph[p1] = q1;
			ph[p2] = q2;
		end
		// route phases to timer channels per motor
		case (m)
			MOTOR_YAW:   begin r.ch0 = ph[PH_B]; r.ch1 = ph[PH_C]; r.ch2 = ph[PH_A]; end
			MOTOR_ROLL:  begin r.ch0 = ph[PH_A]; r.ch1 = ph[PH_C]; r.ch2 = ph[PH_B]; end
			MOTOR_PITCH: begin r.ch0 = ph[PH_C]; r.ch1 = ph[PH_B]; r.ch2 = ph[PH_A]; end
			default:     begin r.ch0 = '0; r.ch1 = '0; r.ch2 = '0; end
		endcase
		r.sector = sec;
		r.motor = m;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending = compare_q.size();

	// track config, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		compare_set_t e;
		if (!arst_n) begin
			alpha_k <= ALPHA_SCALE_RST;
			beta_k <= BETA_SCALE_RST;
			limit_k <= MAX_ACTIVE_RST;
			quarter_k <= QUARTER_RST;
			compare_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ALPHA_SCALE: alpha_k <= cfg_data;
					REG_BETA_SCALE:  beta_k <= cfg_data;
					REG_MAX_ACTIVE:  limit_k <= cfg_data[14:0];
					REG_QUARTER:     quarter_k <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (start && !busy)
				compare_q.push_back(predict_compare(volt_alpha, volt_beta, motor_id));
			if (done) begin
				if (compare_q.size() == 0) begin
					$display("%0t unexpected result transaction", $time);
					fail_count++;
				end else begin
					e = compare_q.pop_front();
					check_field("chan0_compare", e.ch0, chan0_compare);
					check_field("chan1_compare", e.ch1, chan1_compare);
					check_field("chan2_compare", e.ch2, chan2_compare);
					check_field("sector_code", 16'(e.sector), 16'(sector_code));
					check_field("rescaled", 16'(e.resc), 16'(rescaled));
					check_field("motor_echo", 16'(e.motor), 16'(motor_echo));
					if (e.resc) rescale_seen++;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		rescale_seen = 0;
	end
endmodule

@@ bench/space_vector_pwm_tb.sv @@
// space_vector_pwm_tb: stimulus, config phases, watchdog and verdict for space_vector_pwm
// depends on svp_pkg, the block's rtl and space_vector_pwm_checker
module space_vector_pwm_tb;
	import svp_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;

	logic               clk, arst_n, start, busy, done;
	logic signed [15:0] volt_alpha, volt_beta;
	logic        [1:0]  motor_id, motor_echo;
	logic        [15:0] chan0_compare, chan1_compare, chan2_compare;
	logic        [2:0]  sector_code;
	logic               rescaled;
	logic               cfg_valid, cfg_ready;
	logic        [1:0]  cfg_index;
	logic        [15:0] cfg_data;
	int                 fail_count, pending, rescale_seen, items_sent, stall_cycles;

	space_vector_pwm dut (.*);
	space_vector_pwm_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", stall_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_cmd(input logic signed [15:0] va, input logic signed [15:0] vb,
			input logic [1:0] m);
		start <= 1'b1;
		volt_alpha <= va;
		volt_beta <= vb;
		motor_id <= m;
		do @(negedge clk); while (busy);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// let every outstanding transaction come back, then a few quiet cycles
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] ak, input logic [15:0] bk,
			input logic [14:0] lim, input logic [14:0] qp);
		drain();
		write_reg(REG_ALPHA_SCALE, ak);
		write_reg(REG_BETA_SCALE, bk);
		write_reg(REG_MAX_ACTIVE, 16'(lim));
		write_reg(REG_QUARTER, 16'(qp));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// voltages lean toward extremes and small values now and then
	function automatic logic [15:0] pick_volt();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_burst(input int count);
		for (int i = 0; i < count; i++) begin
			// idle gaps except in a stretch of back-to-back commands in the middle of each burst
			if ((i < count / 3 || i > count / 2) && $urandom_range(0, 99) < 7) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			send_cmd(pick_volt(), pick_volt(),
				($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
			if (i == count / 4 && count > 100) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		volt_alpha = '0;
		volt_beta = '0;
		motor_id = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ALPHA_SCALE;
		cfg_data = '0;
		items_sent = 0;
		stall_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each sector direction, every motor code
		send_cmd(16'sh0000, 16'sh0000, MOTOR_YAW);
		send_cmd(16'sh7fff, 16'sh7fff, MOTOR_ROLL);
		send_cmd(16'sh8000, 16'sh8000, MOTOR_PITCH);
		send_cmd(16'sh7fff, 16'sh8000, 2'd3);
		send_cmd(16'sh8000, 16'sh7fff, MOTOR_YAW);
		send_cmd(16'sh4000, 16'sh1000, MOTOR_ROLL);
		send_cmd(16'sh0000, 16'sh4000, MOTOR_PITCH);
		send_cmd(-16'sh4000, 16'sh1000, MOTOR_YAW);
		send_cmd(-16'sh4000, -16'sh1000, MOTOR_ROLL);
		send_cmd(16'sh0000, -16'sh4000, MOTOR_PITCH);
		send_cmd(16'sh4000, -16'sh1000, MOTOR_YAW);
		send_cmd(16'sh0010, 16'sh0008, MOTOR_ROLL);
		send_cmd(-16'sh0001, -16'sh0001, MOTOR_PITCH);
		send_cmd(16'sh0100, -16'sh0100, 2'd3);

		// limit and centre at zero and at their largest
		load_config(16'hffff, 16'hffff, 15'd0, 15'd0);
		send_cmd(16'sh7fff, 16'sh0001, MOTOR_YAW);
		send_cmd(16'sh8000, 16'sh7fff, MOTOR_ROLL);
		send_cmd(16'sh0001, 16'sh0000, MOTOR_PITCH);
		load_config(16'h0000, 16'h0000, 15'h7fff, 15'h7fff);
		send_cmd(16'sh7fff, 16'sh7fff, MOTOR_YAW);
		send_cmd(16'sh8000, 16'sh8000, 2'd3);

		// random phases over several register settings
		load_config(ALPHA_SCALE_RST, BETA_SCALE_RST, MAX_ACTIVE_RST, QUARTER_RST);
		random_burst(500);
		load_config(16'hffff, 16'hffff, 15'd100, 15'h7fff);
		random_burst(350);
		load_config(16'h0000, 16'hffff, 15'h7fff, 15'd0);
		random_burst(250);
		load_config(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
		random_burst(400);
		load_config(16'($urandom), 16'($urandom), 15'($urandom_range(0, 3000)),
			15'($urandom_range(0, 3000)));
		random_burst(400);

		drain();
		$display("sent %0d commands over eight register settings, %0d results rescaled",
			items_sent, rescale_seen);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
